// ===== rtl/lcld_pkg.sv =====
// lcld_pkg: shared types, codes and the log dimming curve for the led channel dimmer
// used by lcld_ctrl, lcld_datapath and led_channel_log_dimmer_unit; no dependencies
`timescale 1ns / 1ps

package lcld_pkg;

  localparam int unsigned CURVE_POINTS = 101;
  localparam int unsigned SRCH_LAST    = CURVE_POINTS - 2;
  localparam int unsigned PCT_MAX      = 1000;
  localparam logic [15:0] LEVEL_FULL   = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_SET_ABS = 2'd0,
    CMD_SET_PCT = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BAD_CH = 2'd1,
    STS_BAD_PCT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_INIT,
    OP_SRCH_STEP,
    OP_PQ,
    OP_PLO,
    OP_PHI,
    OP_PMUL,
    OP_PDIV,
    OP_COMMIT
  } dp_op_e;

  typedef struct packed {
    logic bad;
    logic need_search;
    logic need_interp;
    logic srch_done;
  } dp_stat_t;

  localparam logic [15:0] CURVE_ROM [CURVE_POINTS] = '{
    16'h0000,
    16'h0002, 16'h0003, 16'h0003, 16'h0004, 16'h0004, 16'h0004, 16'h0005, 16'h0006,
    16'h0006, 16'h0007,
    16'h0008, 16'h0009, 16'h0009, 16'h000B, 16'h000C, 16'h000D, 16'h000E, 16'h0010,
    16'h0012, 16'h0014,
    16'h0016, 16'h0018, 16'h001B, 16'h001E, 16'h0021, 16'h0025, 16'h0029, 16'h002D,
    16'h0032, 16'h0037,
    16'h003D, 16'h0044, 16'h004B, 16'h0053, 16'h005C, 16'h0066, 16'h0070, 16'h007C,
    16'h008A, 16'h0098,
    16'h00A9, 16'h00BB, 16'h00CF, 16'h00E5, 16'h00FD, 16'h0118, 16'h0136, 16'h0157,
    16'h017B, 16'h01A3,
    16'h01D0, 16'h0201, 16'h0238, 16'h0274, 16'h02B7, 16'h0301, 16'h0353, 16'h03AD,
    16'h0412, 16'h0480,
    16'h04FB, 16'h0582, 16'h0618, 16'h06BE, 16'h0776, 16'h0841, 16'h0921, 16'h0A1A,
    16'h0B2D, 16'h0C5D,
    16'h0DAD, 16'h0F22, 16'h10BD, 16'h1285, 16'h147D, 16'h16AA, 16'h1913, 16'h1BBD,
    16'h1EB0, 16'h21F3,
    16'h258F, 16'h298D, 16'h2DF8, 16'h32DB, 16'h3842, 16'h3E3D, 16'h44DB, 16'h4C2C,
    16'h5445, 16'h5D3A,
    16'h6723, 16'h7219, 16'h7E3A, 16'h8BA5, 16'h9A7C, 16'hAAE8, 16'hBD12, 16'hD12B,
    16'hE766, 16'hFFFF
  };

  function automatic logic [15:0] curve_at(input logic [6:0] idx);
    logic [15:0] val;
    val = 16'h0000;
    if (32'(idx) < CURVE_POINTS) begin
      val = CURVE_ROM[idx];
    end
    return val;
  endfunction

endpackage

// ===== rtl/led_channel_log_dimmer_unit.sv =====
// led_channel_log_dimmer_unit: top level of the led channel dimmer with log curve
// instantiates lcld_ctrl and lcld_datapath; depends on lcld_pkg
`timescale 1ns / 1ps

// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | command_i, channel_i, level_i
// out     | output    | out_valid_o / out_ready_i| status_o, is_pwm_o, duty_write_o, duty_o,
//         |           |                          | pin_write_o, pin_on_o, read_abs_o,
//         |           |                          | read_percent_o
//
// one item at a time; ready is high only while the sequencer is idle
// set absolute: load in idle, dispatch, then a curve scan of one entry per cycle up to
// the curve index found, then commit to the result register; set percent on pwm:
// dispatch, PQ, PLO, PHI, PMUL, PDIV, commit; reads, errors and on/off set percent: dispatch, commit
// a held result stalls only the commit of the next item, which may already be taken
// reset clears both channel stores and the sequencer at once

module led_channel_log_dimmer_unit #(
  parameter int NUM_CHANNELS     = 4,
  parameter int NUM_PWM_CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  channel_i,
  input  logic [15:0] level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        is_pwm_o,
  output logic        duty_write_o,
  output logic [15:0] duty_o,
  output logic        pin_write_o,
  output logic        pin_on_o,
  output logic [15:0] read_abs_o,
  output logic [9:0]  read_percent_o
);
  import lcld_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;

  lcld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  lcld_datapath #(
    .NUM_CHANNELS     (NUM_CHANNELS),
    .NUM_PWM_CHANNELS (NUM_PWM_CHANNELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .stat_o         (stat),
    .command_i      (command_i),
    .channel_i      (channel_i),
    .level_i        (level_i),
    .status_o       (status_o),
    .is_pwm_o       (is_pwm_o),
    .duty_write_o   (duty_write_o),
    .duty_o         (duty_o),
    .pin_write_o    (pin_write_o),
    .pin_on_o       (pin_on_o),
    .read_abs_o     (read_abs_o),
    .read_percent_o (read_percent_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready still high after an item was taken");

  a_error_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STS_OK)) |->
      (!duty_write_o && !pin_write_o && (duty_o == 16'd0) && !is_pwm_o))
    else $error("error result carries a write");

  a_one_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(duty_write_o && pin_write_o) && (!pin_on_o || pin_write_o))
    else $error("pwm and pin write in the same result");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_percent_o <= 10'(PCT_MAX)))
    else $error("read percent above full scale");

endmodule

// ===== rtl/lcld_ctrl.sv =====
// lcld_ctrl: sequencer for the led dimmer, issues datapath operations per item
// depends on lcld_pkg for operation codes and the status struct
`timescale 1ns / 1ps

module lcld_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  lcld_pkg::dp_stat_t stat_i,
  output lcld_pkg::dp_op_e   op_o
);
  import lcld_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_PQ,
    S_PLO,
    S_PHI,
    S_PMUL,
    S_PDIV,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // operation depends on state and handshakes only, never on datapath status
  always_comb begin
    op_o = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
        end
      end
      S_DISPATCH: begin
        op_o = OP_SRCH_INIT;
      end
      S_SEARCH: begin
        op_o = OP_SRCH_STEP;
      end
      S_PQ: begin
        op_o = OP_PQ;
      end
      S_PLO: begin
        op_o = OP_PLO;
      end
      S_PHI: begin
        op_o = OP_PHI;
      end
      S_PMUL: begin
        op_o = OP_PMUL;
      end
      S_PDIV: begin
        op_o = OP_PDIV;
      end
      S_COMMIT: begin
        if (out_free) begin
          op_o = OP_COMMIT;
        end
      end
      default: begin
        op_o = OP_NONE;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.bad) begin
          state_d = S_COMMIT;
        end else if (stat_i.need_search) begin
          state_d = S_SEARCH;
        end else if (stat_i.need_interp) begin
          state_d = S_PQ;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SEARCH: begin
        if (stat_i.srch_done) begin
          state_d = S_COMMIT;
        end
      end
      S_PQ: begin
        state_d = S_PLO;
      end
      S_PLO: begin
        state_d = S_PHI;
      end
      S_PHI: begin
        state_d = S_PMUL;
      end
      S_PMUL: begin
        state_d = S_PDIV;
      end
      S_PDIV: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/lcld_datapath.sv =====
// lcld_datapath: item registers, channel stores, curve search and interpolation
// depends on lcld_pkg for the curve table, codes and the status struct
`timescale 1ns / 1ps

module lcld_datapath #(
  parameter int NUM_CHANNELS     = 4,
  parameter int NUM_PWM_CHANNELS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcld_pkg::dp_op_e   op_i,
  output lcld_pkg::dp_stat_t stat_o,
  input  logic [1:0]         command_i,
  input  logic [7:0]         channel_i,
  input  logic [15:0]        level_i,
  output logic [1:0]         status_o,
  output logic               is_pwm_o,
  output logic               duty_write_o,
  output logic [15:0]        duty_o,
  output logic               pin_write_o,
  output logic               pin_on_o,
  output logic [15:0]        read_abs_o,
  output logic [9:0]         read_percent_o
);
  import lcld_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [1:0]  cmd_q;
  logic [7:0]  ch_q;
  logic [15:0] lvl_q;
  logic [6:0]  cnt_q;
  logic [6:0]  q_q;
  logic [3:0]  r_q;
  logic [15:0] lo_q, hi_q;
  logic [16:0] prod_q;
  logic [15:0] interp_q;

  logic [15:0] duty_store_q [NUM_CHANNELS];
  logic [9:0]  pct_store_q  [NUM_CHANNELS];

  logic [1:0]  status_q;
  logic        is_pwm_q, duty_write_q, pin_write_q, pin_on_q;
  logic [15:0] duty_q, read_abs_q;
  logic [9:0]  read_percent_q;

  logic        is_pwm, bad_ch, bad_pct, lvl_nz, lvl_full;
  logic [6:0]  rom_addr;
  logic [15:0] rom_val;
  logic        srch_done;
  logic [17:0] qmul;
  logic [9:0]  r_full;
  logic [15:0] diff;
  logic [19:0] prod_w;
  logic [33:0] quo_w;
  logic [16:0] d_w;
  logic [15:0] interp_d;
  logic [9:0]  pct_srch;
  logic [CH_W-1:0] idx;
  logic [15:0] duty_rd;
  logic [9:0]  pct_rd;

  logic [15:0] new_duty;
  logic [9:0]  new_pct;
  logic        st_wr;
  logic [1:0]  status_d;
  logic        is_pwm_d, duty_write_d, pin_write_d, pin_on_d;
  logic [15:0] duty_d, read_abs_d;
  logic [9:0]  read_percent_d;

  assign is_pwm   = ch_q < 8'(NUM_PWM_CHANNELS);
  assign bad_ch   = ch_q >= 8'(NUM_CHANNELS);
  assign bad_pct  = (cmd_q == CMD_SET_PCT) && (lvl_q > 16'(PCT_MAX));
  assign lvl_nz   = (lvl_q != 16'd0);
  assign lvl_full = (lvl_q == LEVEL_FULL);

  always_comb begin
    case (op_i)
      OP_PLO:  rom_addr = q_q;
      OP_PHI:  rom_addr = (q_q == 7'(CURVE_POINTS - 1)) ? q_q : q_q + 7'd1;
      default: rom_addr = cnt_q + 7'd1;
    endcase
  end

  assign rom_val   = curve_at(rom_addr);
  assign srch_done = lvl_full || (cnt_q == 7'(SRCH_LAST)) || (rom_val > lvl_q);

  // divide by ten via reciprocal multiply
  assign qmul     = {8'd0, lvl_q[9:0]} * 18'd205;
  assign r_full   = lvl_q[9:0] - ({q_q, 3'b000} + {2'b00, q_q, 1'b0});
  assign diff     = hi_q - lo_q;
  assign prod_w   = {4'd0, diff} * {16'd0, r_q};
  assign quo_w    = 34'(prod_q) * 34'd52429;
  assign d_w      = {1'b0, lo_q} + {3'b000, quo_w[32:19]};
  assign interp_d = ((d_w[15:0] == 16'd0) && lvl_nz) ? 16'd1 : d_w[15:0];
  assign pct_srch = lvl_full ? 10'(PCT_MAX) : ({cnt_q, 3'b000} + {2'b00, cnt_q, 1'b0});

  assign idx     = ch_q[CH_W-1:0];
  assign duty_rd = duty_store_q[idx];
  assign pct_rd  = pct_store_q[idx];

  assign stat_o.bad         = bad_ch || bad_pct;
  assign stat_o.need_search = (cmd_q == CMD_SET_ABS);
  assign stat_o.need_interp = (cmd_q == CMD_SET_PCT) && is_pwm;
  assign stat_o.srch_done   = srch_done;

  always_comb begin
    new_duty       = 16'd0;
    new_pct        = 10'd0;
    st_wr          = 1'b0;
    status_d       = STS_OK;
    is_pwm_d       = 1'b0;
    duty_write_d   = 1'b0;
    pin_write_d    = 1'b0;
    pin_on_d       = 1'b0;
    duty_d         = 16'd0;
    read_abs_d     = 16'd0;
    read_percent_d = 10'd0;
    if (bad_ch) begin
      status_d = STS_BAD_CH;
    end else if (bad_pct) begin
      status_d = STS_BAD_PCT;
    end else begin
      is_pwm_d = is_pwm;
      case (cmd_q)
        CMD_SET_ABS: begin
          st_wr    = 1'b1;
          new_pct  = pct_srch;
          new_duty = is_pwm ? lvl_q : {15'd0, lvl_nz};
        end
        CMD_SET_PCT: begin
          st_wr = 1'b1;
          if (is_pwm) begin
            new_pct  = lvl_q[9:0];
            new_duty = interp_q;
          end else begin
            new_pct  = lvl_nz ? 10'(PCT_MAX) : 10'd0;
            new_duty = {15'd0, lvl_nz};
          end
        end
        default: begin
          duty_d = duty_rd;
          if (is_pwm) begin
            read_abs_d     = duty_rd;
            read_percent_d = pct_rd;
          end else begin
            read_abs_d     = {15'd0, (duty_rd != 16'd0)};
            read_percent_d = (pct_rd != 10'd0) ? 10'(PCT_MAX) : 10'd0;
          end
        end
      endcase
      if (st_wr) begin
        duty_d       = new_duty;
        duty_write_d = is_pwm;
        pin_write_d  = !is_pwm;
        pin_on_d     = !is_pwm && lvl_nz;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        cmd_q <= command_i;
        ch_q  <= channel_i;
        lvl_q <= level_i;
      end
      OP_SRCH_INIT: begin
        cnt_q <= 7'd0;
      end
      OP_SRCH_STEP: begin
        if (!srch_done) begin
          cnt_q <= cnt_q + 7'd1;
        end
      end
      OP_PQ: begin
        q_q <= qmul[17:11];
      end
      OP_PLO: begin
        r_q  <= r_full[3:0];
        lo_q <= rom_val;
      end
      OP_PHI: begin
        hi_q <= rom_val;
      end
      OP_PMUL: begin
        prod_q <= prod_w[16:0];
      end
      OP_PDIV: begin
        interp_q <= interp_d;
      end
      OP_COMMIT: begin
        status_q       <= status_d;
        is_pwm_q       <= is_pwm_d;
        duty_write_q   <= duty_write_d;
        pin_write_q    <= pin_write_d;
        pin_on_q       <= pin_on_d;
        duty_q         <= duty_d;
        read_abs_q     <= read_abs_d;
        read_percent_q <= read_percent_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        duty_store_q[k] <= 16'd0;
        pct_store_q[k]  <= 10'd0;
      end
    end else if ((op_i == OP_COMMIT) && st_wr) begin
      duty_store_q[idx] <= new_duty;
      pct_store_q[idx]  <= new_pct;
    end
  end

  assign status_o       = status_q;
  assign is_pwm_o       = is_pwm_q;
  assign duty_write_o   = duty_write_q;
  assign duty_o         = duty_q;
  assign pin_write_o    = pin_write_q;
  assign pin_on_o       = pin_on_q;
  assign read_abs_o     = read_abs_q;
  assign read_percent_o = read_percent_q;

endmodule
